// ===== src/rotation_matrix_to_euler_angles_macros.svh =====
// Assertion macros for the rotation matrix to Euler angle block.
// Included by the top level; no other dependencies.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH

// Clocked assertion, disabled during reset
`define RM2E_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked assertion that also checks during reset
`define RM2E_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== src/rm2e_pkg.sv =====
// Shared constants and the CORDIC angle table for the Euler angle block.
// No dependencies.
`default_nettype none
package rm2e_pkg;

   // Datapath widths
   localparam int WORD_W      = 64;   // CORDIC x/y word
   localparam int IN_W        = 34;   // CORDIC operand before prescale
   localparam int Z_W         = 34;   // angle accumulator, 2^31 = pi
   localparam int ANG_W       = 16;   // output binary angle
   localparam int HYP_W       = 32;   // root width
   localparam int PRESCALE_SH = 28;
   localparam int TABLE_LEN   = 30;
   localparam int ROOT_STEPS  = 32;

   localparam logic signed [Z_W-1:0]   HALF_PI_Z = 34'sh0_4000_0000;
   localparam logic signed [ANG_W-1:0] ANG_PI_SAT = 16'sh7fff;
   localparam logic signed [ANG_W-1:0] ANG_POS_HALF = 16'sh4000;
   localparam logic signed [ANG_W-1:0] ANG_NEG_HALF = 16'shc000;
   localparam logic signed [ANG_W-1:0] ANG_ZERO = 16'sh0000;

   // round(atan(2^-i) * 2^31 / pi)
   function automatic logic [31:0] atan_entry(input int unsigned idx);
      logic [31:0] v;
      unique case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         24: v = 32'd41;
         25: v = 32'd20;
         26: v = 32'd10;
         27: v = 32'd5;
         28: v = 32'd3;
         29: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== src/rotation_matrix_to_euler_angles.sv =====
// Pipeline: the hypot root (squares, sum, root bits), then CORDIC entry, micro-rotations and output.
// Throughput: one matrix per cycle; the whole pipeline holds while a result
// waits on rsp_ready, so one accepted request yields one response in order.
// Reset clears only the stage valid bits; datapath registers are not reset.
// Uses rm2e_pkg, rm2e_hyp, rm2e_cordic and the assertion macro header.
`default_nettype none
`include "rotation_matrix_to_euler_angles_macros.svh"
module rotation_matrix_to_euler_angles #(
   parameter int COEFF_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [COEFF_WIDTH-1:0]        req_r00,
   input  wire logic signed [COEFF_WIDTH-1:0]        req_r10,
   input  wire logic signed [COEFF_WIDTH-1:0]        req_r20,
   input  wire logic signed [COEFF_WIDTH-1:0]        req_r21,
   input  wire logic signed [COEFF_WIDTH-1:0]        req_r22,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [rm2e_pkg::ANG_W-1:0]         rsp_first_angle,
   output logic signed [rm2e_pkg::ANG_W-1:0]         rsp_second_angle,
   output logic signed [rm2e_pkg::ANG_W-1:0]         rsp_third_angle
);
   localparam int CW     = COEFF_WIDTH;
   localparam int G      = 32 - CW;
   localparam int IW     = rm2e_pkg::IN_W;
   localparam int SIDE_W = 4 * CW + IW;
   localparam int LAT    = rm2e_pkg::ROOT_STEPS + 2 + CORDIC_STAGES + 2;

   logic                    adv;
   logic [LAT-1:0]          valid_ff, valid_in;
   logic signed [IW-1:0]    num;
   logic [SIDE_W-1:0]       side_in, side_out;
   logic [rm2e_pkg::HYP_W-1:0] hyp;
   logic signed [CW-1:0]    d_r00, d_r10, d_r21, d_r22;
   logic signed [IW-1:0]    d_num;

   // Advance the whole pipeline unless the output holds an untaken response
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Track stage occupancy
   assign valid_in = {valid_ff[LAT-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end
   assign rsp_valid = valid_ff[LAT-1];

   // Pitch numerator: -r20 scaled to the root's guard bits
   assign num     = -(IW'(req_r20) <<< G);
   assign side_in = {req_r00, req_r10, req_r21, req_r22, num};

   rm2e_hyp #(.CW(CW), .SIDE_W(SIDE_W)) u_hyp (
      .clock    (clock),
      .adv      (adv),
      .a        (req_r21),
      .b        (req_r22),
      .side_in  (side_in),
      .hyp_out  (hyp),
      .side_out (side_out)
   );

   assign {d_r00, d_r10, d_r21, d_r22, d_num} = side_out;

   rm2e_cordic #(.STAGES(CORDIC_STAGES)) u_first (
      .clock (clock),
      .adv   (adv),
      .y_in  (IW'(d_r10)),
      .x_in  (IW'(d_r00)),
      .angle (rsp_first_angle)
   );

   rm2e_cordic #(.STAGES(CORDIC_STAGES)) u_second (
      .clock (clock),
      .adv   (adv),
      .y_in  (d_num),
      .x_in  ($signed({{(IW - rm2e_pkg::HYP_W){1'b0}}, hyp})),
      .angle (rsp_second_angle)
   );

   rm2e_cordic #(.STAGES(CORDIC_STAGES)) u_third (
      .clock (clock),
      .adv   (adv),
      .y_in  (IW'(d_r21)),
      .x_in  (IW'(d_r22)),
      .angle (rsp_third_angle)
   );

   // Occupancy checks
   `RM2E_ASSERT(a_enter, (req_valid && req_ready) |=> valid_ff[0], "accepted request not tracked")
   `RM2E_ASSERT(a_bubble, (!req_valid && req_ready) |=> !valid_ff[0], "bubble became valid")
   `RM2E_ASSERT(a_hold, (!req_ready) |=> $stable(valid_ff), "pipeline moved while held")
endmodule
`default_nettype wire

// ===== src/rm2e_hyp.sv =====
// Pipelined hypot: squares, sum, then a one-bit-per-stage integer root.
// Carries a side payload alongside. Uses rm2e_pkg.
`default_nettype none
module rm2e_hyp #(
   parameter int CW     = 16,
   parameter int SIDE_W = 8
) (
   input  wire logic                           clock,
   input  wire logic                           adv,
   input  wire logic signed [CW-1:0]           a,
   input  wire logic signed [CW-1:0]           b,
   input  wire logic [SIDE_W-1:0]              side_in,
   output logic [rm2e_pkg::HYP_W-1:0]          hyp_out,
   output logic [SIDE_W-1:0]                   side_out
);
   localparam int G  = 32 - CW;
   localparam int WW = rm2e_pkg::WORD_W;
   localparam int NS = rm2e_pkg::ROOT_STEPS;

   logic signed [2*CW-1:0] sqa_ff, sqb_ff;
   logic [SIDE_W-1:0]      side_a_ff;
   logic [WW-1:0]          n_ff [0:NS];
   logic [WW-1:0]          r_ff [0:NS];
   logic [SIDE_W-1:0]      side_ff [0:NS];
   logic [WW-1:0]          sum_w;

   // Square both operands
   always_ff @(posedge clock) begin
      if (adv) begin
         sqa_ff    <= a * a;
         sqb_ff    <= b * b;
         side_a_ff <= side_in;
      end
   end

   // Add and scale into the root operand
   assign sum_w = WW'($unsigned(sqa_ff)) + WW'($unsigned(sqb_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0]    <= sum_w << (2 * G);
         r_ff[0]    <= '0;
         side_ff[0] <= side_a_ff;
      end
   end

   // One result bit per stage
   for (genvar k = 0; k < NS; k++) begin : g_root
      localparam logic [WW-1:0] BIT = WW'(1) << (62 - 2 * k);
      logic [WW-1:0] t, n_in, r_in;
      always_comb begin
         t = r_ff[k] + BIT;
         if (n_ff[k] >= t) begin
            n_in = n_ff[k] - t;
            r_in = (r_ff[k] >> 1) + BIT;
         end else begin
            n_in = n_ff[k];
            r_in = r_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[k+1]    <= n_in;
            r_ff[k+1]    <= r_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign hyp_out  = r_ff[NS][rm2e_pkg::HYP_W-1:0];
   assign side_out = side_ff[NS];
endmodule
`default_nettype wire

// ===== src/rm2e_cordic.sv =====
// Pipelined vectoring CORDIC atan2, one stage per iteration, with
// entry stage for special cases and quadrant fold. Uses rm2e_pkg.
`default_nettype none
module rm2e_cordic #(
   parameter int STAGES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                adv,
   input  wire logic signed [rm2e_pkg::IN_W-1:0]    y_in,
   input  wire logic signed [rm2e_pkg::IN_W-1:0]    x_in,
   output logic signed [rm2e_pkg::ANG_W-1:0]        angle
);
   localparam int WW = rm2e_pkg::WORD_W;
   localparam int ZW = rm2e_pkg::Z_W;
   localparam int AW = rm2e_pkg::ANG_W;

   logic signed [WW-1:0] x_ff [0:STAGES];
   logic signed [WW-1:0] y_ff [0:STAGES];
   logic signed [ZW-1:0] z_ff [0:STAGES];
   logic                 spec_ff [0:STAGES];
   logic signed [AW-1:0] sval_ff [0:STAGES];
   logic signed [AW-1:0] angle_ff;

   logic signed [WW-1:0] xs, ys, x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;
   logic                 spec_in;
   logic signed [AW-1:0] sval_in;

   // Detect axis cases, prescale, fold left half plane
   always_comb begin
      xs      = WW'(x_in) <<< rm2e_pkg::PRESCALE_SH;
      ys      = WW'(y_in) <<< rm2e_pkg::PRESCALE_SH;
      spec_in = 1'b0;
      sval_in = rm2e_pkg::ANG_ZERO;
      x0_in   = xs;
      y0_in   = ys;
      z0_in   = '0;
      priority if (y_in == '0) begin
         spec_in = 1'b1;
         sval_in = (x_in < 0) ? rm2e_pkg::ANG_PI_SAT : rm2e_pkg::ANG_ZERO;
      end else if (x_in == '0) begin
         spec_in = 1'b1;
         sval_in = (y_in > 0) ? rm2e_pkg::ANG_POS_HALF : rm2e_pkg::ANG_NEG_HALF;
      end else if (x_in < 0) begin
         if (y_in > 0) begin
            x0_in = ys;
            y0_in = -xs;
            z0_in = rm2e_pkg::HALF_PI_Z;
         end else begin
            x0_in = -ys;
            y0_in = xs;
            z0_in = -rm2e_pkg::HALF_PI_Z;
         end
      end else begin
         // right half plane: take the prescaled operands as they are
         x0_in = xs;
         y0_in = ys;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         spec_ff[0] <= spec_in;
         sval_ff[0] <= sval_in;
      end
   end

   // Micro-rotations
   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ANG = ZW'(rm2e_pkg::atan_entry(i));
      logic signed [WW-1:0] dx, dy;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + dy;
               y_ff[i+1] <= y_ff[i] - dx;
               z_ff[i+1] <= z_ff[i] + ANG;
            end else begin
               x_ff[i+1] <= x_ff[i] - dy;
               y_ff[i+1] <= y_ff[i] + dx;
               z_ff[i+1] <= z_ff[i] - ANG;
            end
            spec_ff[i+1] <= spec_ff[i];
            sval_ff[i+1] <= sval_ff[i];
         end
      end
   end

   // Round to 16-bit binary angle and clamp
   logic signed [ZW-1:0]    zr;
   logic signed [ZW-17:0]   za;
   logic signed [AW-1:0]    angle_in;
   always_comb begin
      zr = z_ff[STAGES] + ZW'(32768);
      za = (ZW-16)'(zr >>> 16);
      if (spec_ff[STAGES]) begin
         angle_in = sval_ff[STAGES];
      end else if (za > (ZW-16)'(32767)) begin
         angle_in = rm2e_pkg::ANG_PI_SAT;
      end else if (za < -(ZW-16)'(32768)) begin
         angle_in = 16'sh8000;
      end else begin
         angle_in = za[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for rotation_matrix_to_euler_angles: drives matrix requests, predicts
// the three CORDIC angles in place and checks every response in order.
// Depends on rm2e_pkg and the rotation_matrix_to_euler_angles RTL.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW      = 16;
   localparam int STAGES  = 16;
   localparam int LATENCY = 36 + STAGES;
   localparam longint CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic signed [rm2e_pkg::ANG_W-1:0] first;
      logic signed [rm2e_pkg::ANG_W-1:0] second;
      logic signed [rm2e_pkg::ANG_W-1:0] third;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_r00 = '0, req_r10 = '0, req_r20 = '0, req_r21 = '0,
                         req_r22 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [rm2e_pkg::ANG_W-1:0] rsp_first_angle, rsp_second_angle, rsp_third_angle;

   angles_type expected_angles[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   longint  cycles = 0;

   rotation_matrix_to_euler_angles #(.COEFF_WIDTH(CW), .CORDIC_STAGES(STAGES)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_r00(req_r00), .req_r10(req_r10), .req_r20(req_r20),
      .req_r21(req_r21), .req_r22(req_r22),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_first_angle(rsp_first_angle), .rsp_second_angle(rsp_second_angle),
      .rsp_third_angle(rsp_third_angle)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Floor shift for 64-bit signed words
   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint atan_step(input int i);
      case (i)
         0: return 536870912;   1: return 316933406;   2: return 167458907;
         3: return 85004756;    4: return 42667331;    5: return 21354465;
         6: return 10679838;    7: return 5340245;     8: return 2670163;
         9: return 1335087;     10: return 667544;     11: return 333772;
         12: return 166886;     13: return 83443;      14: return 41722;
         15: return 20861;      16: return 10430;      17: return 5215;
         18: return 2608;       19: return 1304;       20: return 652;
         21: return 326;        22: return 163;        23: return 81;
         24: return 41;         25: return 20;         26: return 10;
         27: return 5;          28: return 3;          default: return 1;
      endcase
   endfunction

   // Vectoring CORDIC on integer operands, rounded to a 16-bit binary angle
   function automatic logic signed [rm2e_pkg::ANG_W-1:0] vector_angle(input longint y0,
                                                                       input longint x0);
      longint x, y, z, t, dx, dy, a;
      x = x0;
      y = y0;
      z = 0;
      if (y == 0) return (x < 0) ? rm2e_pkg::ANG_PI_SAT : rm2e_pkg::ANG_ZERO;
      if (x == 0) return (y > 0) ? rm2e_pkg::ANG_POS_HALF : rm2e_pkg::ANG_NEG_HALF;
      x = x <<< rm2e_pkg::PRESCALE_SH;
      y = y <<< rm2e_pkg::PRESCALE_SH;
      // turn into the right half plane
      if (x < 0) begin
         if (y > 0) begin
            t = x; x = y; y = -t; z = 64'sd1 <<< 30;
         end else begin
            t = x; x = -y; y = t; z = -(64'sd1 <<< 30);
         end
      end
      for (int i = 0; i < STAGES && i < rm2e_pkg::TABLE_LEN; i++) begin
         dx = floor_shift(x, i);
         dy = floor_shift(y, i);
         if (y >= 0) begin
            x += dy; y -= dx; z += atan_step(i);
         end else begin
            x -= dy; y += dx; z -= atan_step(i);
         end
      end
      a = floor_shift(z + 32768, 16);
      if (a > 32767) a = 32767;
      if (a < -32768) a = -32768;
      return a[rm2e_pkg::ANG_W-1:0];
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic angles_type euler_angles(input logic signed [CW-1:0] r00, r10, r20,
                                               r21, r22);
      angles_type res;
      longint unsigned sum;
      longint hyp, num;
      sum = longint'(r21) * longint'(r21) + longint'(r22) * longint'(r22);
      hyp = int_sqrt(sum << (2 * (32 - CW)));
      num = -longint'(r20) * (64'sd1 <<< (32 - CW));
      res.first  = vector_angle(r10, r00);
      res.second = vector_angle(num, hyp);
      res.third  = vector_angle(r21, r22);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Send one request, idling beforehand at the current rate; valid stays
   // high after acceptance until the next idle cycle or drain
   task automatic send_matrix(input logic signed [CW-1:0] r00, r10, r20, r21, r22);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_r00 <= r00; req_r10 <= r10; req_r20 <= r20; req_r21 <= r21; req_r22 <= r22;
      expected_angles.push_back(euler_angles(r00, r10, r20, r21, r22));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold until every expected response has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   // Randomize the response-side stall
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Check each response against the oldest prediction
   always @(posedge clock) begin
      angles_type want;
      cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_angles.size() == 0) begin
            report_mismatch("unexpected response", rsp_first_angle, 0);
         end else begin
            want = expected_angles.pop_front();
            if (rsp_first_angle !== want.first)
               report_mismatch("first_angle", rsp_first_angle, want.first);
            if (rsp_second_angle !== want.second)
               report_mismatch("second_angle", rsp_second_angle, want.second);
            if (rsp_third_angle !== want.third)
               report_mismatch("third_angle", rsp_third_angle, want.third);
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("rotation_matrix_to_euler_angles test failed");
         $finish;
      end
   end

   function automatic logic signed [CW-1:0] rand_entry();
      return CW'($signed($urandom_range(32768)) - 16384);
   endfunction

   // Extremes, axis cases and the negative-x half plane
   task automatic test_directed();
      send_matrix(0, 0, 0, 0, 0);
      send_matrix(16384, 0, 0, 0, 16384);
      send_matrix(-16384, 0, 16384, 0, -16384);
      send_matrix(0, 16384, -16384, 16384, 0);
      send_matrix(0, -16384, 0, -16384, 0);
      send_matrix(-16384, 16384, 0, 16384, -16384);
      send_matrix(-16384, -16384, 0, -16384, -16384);
      send_matrix(16384, 16384, 16384, 16384, 16384);
      send_matrix(16384, -16384, -16384, -16384, 16384);
      send_matrix(-1, 1, 1, 1, -1);
      send_matrix(-1, -1, -1, -1, -1);
      send_matrix(1, 0, 0, 0, 1);
      send_matrix(-32768, 32767, -32768, 32767, -32768);
      send_matrix(32767, -32768, 32767, -32768, 32767);
      send_matrix(-32768, -32768, 32767, -32768, -32768);
      send_matrix(-5000, 1, 0, 1, -5000);
      send_matrix(-5000, -1, 0, -1, -5000);
      send_matrix(11585, 11585, -11585, 11585, 11585);
      send_matrix(16384, 0, 12345, 0, 0);
   endtask

   // Random matrices, mostly in range with some full-width noise
   task automatic test_random(input int count, input int idle, input int stall);
      logic signed [CW-1:0] e[5];
      send_idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 5; k++) begin
            case ($urandom_range(9))
               0: e[k] = CW'($urandom());
               1: e[k] = CW'($signed($urandom_range(8)) - 4);
               2: e[k] = 0;
               default: e[k] = rand_entry();
            endcase
         end
         send_matrix(e[0], e[1], e[2], e[3], e[4]);
      end
   endtask

   // Hold the sender until the pipeline is empty, then resume
   task automatic test_drain_pause();
      send_idle_pct = 0;
      stall_pct = 30;
      for (int n = 0; n < 20; n++) send_matrix(rand_entry(), rand_entry(), rand_entry(),
                                               rand_entry(), rand_entry());
      wait_drained();
      for (int n = 0; n < 20; n++) send_matrix(rand_entry(), rand_entry(), rand_entry(),
                                               rand_entry(), rand_entry());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500, 0, 0);
      test_random(250, 88, 0);
      test_random(250, 0, 88);
      test_random(250, 11, 11);
      test_drain_pause();
      test_random(160, 0, 0);
      stall_pct = 0;
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("rotation_matrix_to_euler_angles test passed");
      else
         $display("rotation_matrix_to_euler_angles test failed");
      $finish;
   end
endmodule
`default_nettype wire
